>>> hdl/srr_pkg.sv
// shared types, constants and defaults of the signature rrip replacement unit
`timescale 1ns / 1ps

package srr_pkg;

   localparam int NUM_SETS_DEF    = 2048;
   localparam int NUM_WAYS_DEF    = 16;
   localparam int SIG_ENTRIES_DEF = 8192;

   localparam int LINE_W = 18;

   localparam logic [2:0] RRV_MAX     = 3'd7;
   localparam logic [2:0] RRV_NEAR    = 3'd0;
   localparam logic [2:0] RRV_PF_NEAR = 3'd1;
   localparam logic [2:0] RRV_LONG    = 3'd6;
   localparam logic [2:0] CTR_MAX     = 3'd7;
   localparam logic [2:0] CTR_MIN     = 3'd0;
   localparam logic [2:0] CTR_RESET   = 3'd1;

   localparam logic [1:0] TYPE_PREFETCH  = 2'd2;
   localparam logic [1:0] TYPE_WRITEBACK = 2'd3;

   localparam logic OP_VICTIM = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef struct packed {
      logic [2:0]  rrv;
      logic        pf;
      logic        reused;
      logic [12:0] sig;
   } line_type;

   localparam line_type LINE_RESET = '{rrv: RRV_MAX, pf: 1'b0, reused: 1'b0, sig: 13'd0};

   typedef struct packed {
      logic        operation;
      logic [10:0] set_index;
      logic [3:0]  way_index;
      logic [1:0]  access_type;
      logic        was_hit;
      logic        sampled_set;
      logic        train_chance;
      logic        noop;
      logic [12:0] nsig;
   } item_type;

   typedef struct packed {
      logic accepting;
      logic pop;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_CTR_WR,
      ST_CTR_RD2,
      ST_INSERT,
      ST_WRITE,
      ST_VIC
   } state_type;

endpackage

>>> hdl/srr_ifs.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface srr_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [10:0] set_index;
   logic [3:0]  way_index;
   logic [11:0] pc_low;
   logic [1:0]  access_type;
   logic        was_hit;
   logic        sampled_set;
   logic        train_chance;

   modport source (output valid, operation, set_index, way_index, pc_low, access_type,
                   was_hit, sampled_set, train_chance, input ready);
   modport sink (input valid, operation, set_index, way_index, pc_low, access_type,
                 was_hit, sampled_set, train_chance, output ready);
endinterface

interface srr_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] victim_way;

   modport source (output valid, victim_way, input ready);
   modport sink (input valid, victim_way, output ready);
endinterface

>>> hdl/srr_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module srr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/srr_front.sv
// request front end: classifies requests and queues them for the sequencer
`timescale 1ns / 1ps

module srr_front #(
   parameter int NUM_WAYS = srr_pkg::NUM_WAYS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   srr_req_if.sink                  req_ch,
   input  srr_pkg::back_status_type status,
   output logic                     q_valid,
   output srr_pkg::item_type        q_item
);

   srr_pkg::item_type q_ff [2];
   srr_pkg::item_type item;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   always_comb begin
      item.operation    = req_ch.operation;
      item.set_index    = req_ch.set_index;
      item.way_index    = req_ch.way_index;
      item.access_type  = req_ch.access_type;
      item.was_hit      = req_ch.was_hit;
      item.sampled_set  = req_ch.sampled_set;
      item.train_chance = req_ch.train_chance;
      item.nsig         = {req_ch.pc_low, req_ch.access_type == srr_pkg::TYPE_PREFETCH};
      // updates that cannot change any state
      item.noop = (req_ch.operation == srr_pkg::OP_UPDATE) &&
                  ((32'(req_ch.way_index) >= NUM_WAYS) ||
                   (req_ch.was_hit && req_ch.access_type == srr_pkg::TYPE_WRITEBACK));
   end

   assign req_ch.ready = (cnt_ff != 2'd2) && status.accepting;
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = cnt_ff != 2'd0;
   assign q_item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ status.pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

>>> hdl/srr_back.sv
// back end sequencer: set row and signature counter read-modify-write
`timescale 1ns / 1ps

module srr_back #(
   parameter int NUM_SETS    = srr_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS    = srr_pkg::NUM_WAYS_DEF,
   parameter int SIG_ENTRIES = srr_pkg::SIG_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     always_train_prefetch,
   input  logic                     q_valid,
   input  srr_pkg::item_type        q_item,
   output srr_pkg::back_status_type status,
   srr_rsp_if.source                rsp_ch
);

   localparam int SET_W = $clog2(NUM_SETS);
   localparam int WAY_W = $clog2(NUM_WAYS);
   localparam int SIG_W = $clog2(SIG_ENTRIES);
   localparam int ROW_W = NUM_WAYS * srr_pkg::LINE_W;
   localparam int CLR_N = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
   localparam int CLR_W = $clog2(CLR_N);

   srr_pkg::state_type state_ff, state_in;
   srr_pkg::item_type  item_ff, item_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   srr_pkg::line_type  line_ff, line_in;
   logic [SIG_W-1:0]   old_sig_ff, old_sig_in;
   logic               inc_ff, inc_in;
   logic [2:0]         add_ff, add_in;
   logic [CLR_W-1:0]   clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_way_ff, rsp_way_in;

   logic               row_we, row_re;
   logic [SET_W-1:0]   row_waddr, row_raddr;
   logic [ROW_W-1:0]   row_wdata, row_rdata;
   logic               ctr_we, ctr_re;
   logic [SIG_W-1:0]   ctr_waddr, ctr_raddr;
   logic [2:0]         ctr_wdata, ctr_rdata;

   logic [WAY_W-1:0]   way_sel;
   srr_pkg::line_type  cur_line, nl, tmp;
   logic [ROW_W-1:0]   row_patch, row_aged;
   logic [2:0]         top;
   logic [WAY_W-1:0]   vic;
   logic               found, train;

   srr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
      .clock(clock), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
      .re(row_re), .raddr(row_raddr), .rdata(row_rdata)
   );

   srr_ram #(.WIDTH(3), .DEPTH(SIG_ENTRIES)) u_ctr_ram (
      .clock(clock), .we(ctr_we), .waddr(ctr_waddr), .wdata(ctr_wdata),
      .re(ctr_re), .raddr(ctr_raddr), .rdata(ctr_rdata)
   );

   assign way_sel  = WAY_W'(item_ff.way_index);
   assign cur_line = srr_pkg::line_type'(row_rdata[way_sel*srr_pkg::LINE_W +: srr_pkg::LINE_W]);

   // row with the updated line patched in, and the aged row with its victim
   always_comb begin
      tmp   = srr_pkg::LINE_RESET;
      found = 1'b0;
      vic   = '0;
      top   = 3'd0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         row_patch[w*srr_pkg::LINE_W +: srr_pkg::LINE_W] = (WAY_W'(w) == way_sel) ?
            line_ff : row_ff[w*srr_pkg::LINE_W +: srr_pkg::LINE_W];
         tmp     = srr_pkg::line_type'(row_ff[w*srr_pkg::LINE_W +: srr_pkg::LINE_W]);
         tmp.rrv = tmp.rrv + add_ff;
         row_aged[w*srr_pkg::LINE_W +: srr_pkg::LINE_W] = tmp;
         if (!found && tmp.rrv == srr_pkg::RRV_MAX) begin
            found = 1'b1;
            vic   = WAY_W'(w);
         end
         tmp = srr_pkg::line_type'(row_rdata[w*srr_pkg::LINE_W +: srr_pkg::LINE_W]);
         if (tmp.rrv > top) begin
            top = tmp.rrv;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      row_in       = row_ff;
      line_in      = line_ff;
      old_sig_in   = old_sig_ff;
      inc_in       = inc_ff;
      add_in       = add_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_way_in   = rsp_way_ff;
      row_we       = 1'b0;
      row_waddr    = SET_W'(item_ff.set_index);
      row_wdata    = row_patch;
      row_re       = 1'b0;
      row_raddr    = SET_W'(q_item.set_index);
      ctr_we       = 1'b0;
      ctr_waddr    = old_sig_ff;
      ctr_wdata    = ctr_rdata;
      ctr_re       = 1'b0;
      ctr_raddr    = old_sig_ff;
      status.pop       = 1'b0;
      status.accepting = state_ff != srr_pkg::ST_CLEAR;
      nl    = cur_line;
      train = 1'b0;

      case (state_ff)
         srr_pkg::ST_CLEAR: begin
            row_we    = 32'(clr_ff) < NUM_SETS;
            row_waddr = SET_W'(clr_ff);
            row_wdata = {NUM_WAYS{srr_pkg::LINE_RESET}};
            ctr_we    = 32'(clr_ff) < SIG_ENTRIES;
            ctr_waddr = SIG_W'(clr_ff);
            ctr_wdata = srr_pkg::CTR_RESET;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = srr_pkg::ST_IDLE;
            end
         end
         srr_pkg::ST_IDLE: begin
            if (q_valid) begin
               status.pop = 1'b1;
               item_in    = q_item;
               row_re     = !q_item.noop;
               if (!q_item.noop) begin
                  state_in = srr_pkg::ST_ROW;
               end
            end
         end
         srr_pkg::ST_ROW: begin
            row_in     = row_rdata;
            old_sig_in = SIG_W'(cur_line.sig);
            ctr_raddr  = SIG_W'(cur_line.sig);
            if (item_ff.operation == srr_pkg::OP_VICTIM) begin
               add_in   = srr_pkg::RRV_MAX - top;
               state_in = srr_pkg::ST_VIC;
            end else if (item_ff.was_hit) begin
               if (item_ff.access_type == srr_pkg::TYPE_PREFETCH && cur_line.pf) begin
                  if (item_ff.sampled_set && (item_ff.train_chance || always_train_prefetch)) begin
                     train     = 1'b1;
                     nl.reused = 1'b1;
                  end
               end else begin
                  nl.rrv = cur_line.pf ? srr_pkg::RRV_MAX : srr_pkg::RRV_NEAR;
                  nl.pf  = 1'b0;
                  if (item_ff.sampled_set && !cur_line.reused) begin
                     train     = 1'b1;
                     nl.reused = 1'b1;
                  end
               end
               line_in  = nl;
               inc_in   = 1'b1;
               ctr_re   = train;
               state_in = train ? srr_pkg::ST_CTR_WR : srr_pkg::ST_WRITE;
            end else begin
               // miss: in a sampled set train on the evicted line, then look up the new signature
               if (item_ff.sampled_set) begin
                  nl.reused = 1'b0;
                  nl.sig    = item_ff.nsig;
               end
               nl.pf    = item_ff.access_type == srr_pkg::TYPE_PREFETCH;
               line_in  = nl;
               inc_in   = cur_line.reused;
               ctr_re   = item_ff.sampled_set;
               state_in = item_ff.sampled_set ? srr_pkg::ST_CTR_WR : srr_pkg::ST_CTR_RD2;
            end
         end
         srr_pkg::ST_CTR_WR: begin
            ctr_we = 1'b1;
            if (inc_ff) begin
               ctr_wdata = (ctr_rdata == srr_pkg::CTR_MAX) ? ctr_rdata : ctr_rdata + 3'd1;
            end else begin
               ctr_wdata = (ctr_rdata == srr_pkg::CTR_MIN) ? ctr_rdata : ctr_rdata - 3'd1;
            end
            state_in = item_ff.was_hit ? srr_pkg::ST_WRITE : srr_pkg::ST_CTR_RD2;
         end
         srr_pkg::ST_CTR_RD2: begin
            ctr_re    = 1'b1;
            ctr_raddr = SIG_W'(item_ff.nsig);
            state_in  = srr_pkg::ST_INSERT;
         end
         srr_pkg::ST_INSERT: begin
            nl = line_ff;
            if (item_ff.access_type == srr_pkg::TYPE_WRITEBACK || ctr_rdata == srr_pkg::CTR_MIN) begin
               nl.rrv = srr_pkg::RRV_MAX;
            end else if (ctr_rdata == srr_pkg::CTR_MAX) begin
               nl.rrv = (item_ff.access_type == srr_pkg::TYPE_PREFETCH) ?
                        srr_pkg::RRV_PF_NEAR : srr_pkg::RRV_NEAR;
            end else begin
               nl.rrv = srr_pkg::RRV_LONG;
            end
            line_in  = nl;
            state_in = srr_pkg::ST_WRITE;
         end
         srr_pkg::ST_WRITE: begin
            row_we   = 1'b1;
            state_in = srr_pkg::ST_IDLE;
         end
         srr_pkg::ST_VIC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               row_we       = 1'b1;
               row_wdata    = row_aged;
               rsp_valid_in = 1'b1;
               rsp_way_in   = 4'(vic);
               state_in     = srr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srr_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      row_ff     <= row_in;
      line_ff    <= line_in;
      old_sig_ff <= old_sig_in;
      inc_ff     <= inc_in;
      add_ff     <= add_in;
      rsp_way_ff <= rsp_way_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.victim_way = rsp_way_ff;

endmodule

>>> hdl/signature_rrip_replacement_unit.sv
// Signature-based rrip replacement engine for a last-level cache. Requests
// enter a two-word queue; a sequencer then reads the addressed set row (all
// ways' 3-bit re-reference value, prefetched and reused marks and 13-bit
// signature) from one ram and signature counters from a second ram, and
// writes them back. A victim request reads the row, then ages it and
// answers once any response stall clears; an update that changes nothing
// is only dequeued; a hit writes back the row, with a counter read and
// write between when it trains; a miss reads the counter of the new
// signature before the row write, in a sampled set after training the old.
// After reset a clearing pass over max(NUM_SETS, SIG_ENTRIES) addresses
// initializes both rams; no request word is accepted until it ends. The csr
// register may be written at any time the block is idle.
`timescale 1ns / 1ps

module signature_rrip_replacement_unit #(
   parameter int NUM_SETS    = srr_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS    = srr_pkg::NUM_WAYS_DEF,
   parameter int SIG_ENTRIES = srr_pkg::SIG_ENTRIES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   srr_req_if.sink   req_ch,
   srr_rsp_if.source rsp_ch,
   input  logic      csr_we,
   input  logic      csr_wdata
);

   logic                     atp_ff, atp_in;
   logic                     q_valid;
   srr_pkg::item_type        q_item;
   srr_pkg::back_status_type status;

   assign atp_in = csr_we ? csr_wdata : atp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         atp_ff <= 1'b0;
      end else begin
         atp_ff <= atp_in;
      end
   end

   srr_front #(.NUM_WAYS(NUM_WAYS)) u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .status(status),
      .q_valid(q_valid), .q_item(q_item)
   );

   srr_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_ENTRIES(SIG_ENTRIES)) u_back (
      .clock(clock), .reset(reset), .always_train_prefetch(atp_ff),
      .q_valid(q_valid), .q_item(q_item), .status(status), .rsp_ch(rsp_ch)
   );

endmodule
